/* rtl/arb_pkg.sv */
// Shared types and constants for the audio ring buffer with adaptive frames.
// No dependencies; the other files that use it refer to this package by scoped names.
package arb_pkg;

	// store geometry
	localparam int BUFFER_BYTES = 4096;
	localparam int STORE_WORDS  = BUFFER_BYTES / 2;
	localparam int SAMPLE_AW    = $clog2(STORE_WORDS);
	localparam int BANK_AW      = SAMPLE_AW - 1;
	localparam int FILL_W       = $clog2(BUFFER_BYTES) + 1;

	// frame sizing limits in 32-bit words, and the sizing step in bytes
	localparam logic [5:0] MIN_FRAME_WORDS = 6'd2;
	localparam logic [5:0] MAX_FRAME_WORDS = 6'd48;
	localparam logic [7:0] STEP_BYTES      = 8'd4;

	// input item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_FRAME = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FILLING  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_NOMINAL = 2'd0,
		REG_LOWER   = 2'd1,
		REG_UPPER   = 2'd2,
		REG_START   = 2'd3
	} reg_idx_t;

	// access request to the two-bank sample store
	typedef struct packed {
		logic               we;
		logic               wbank;
		logic [BANK_AW-1:0] waddr;
		logic [15:0]        wdata;
		logic               re;
		logic [BANK_AW-1:0] raddr;
	} mem_req_t;

endpackage

/* rtl/arb_stream_if.sv */
// Valid/ready channel interfaces for sample/frame-request items and results.
// Depends on nothing; widths follow the item fields.
interface arb_in_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [15:0] sample;
	logic [11:0]        block_len;
	logic               first_of_block;
	logic               last_of_block;

	modport source (output valid, kind, sample, block_len, first_of_block, last_of_block,
		input ready);
	modport sink (input valid, kind, sample, block_len, first_of_block, last_of_block,
		output ready);
endinterface

interface arb_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] frame_word;
	logic [7:0]  frame_bytes;
	logic        last;

	modport source (output valid, status, frame_word, frame_bytes, last, input ready);
	modport sink (input valid, status, frame_word, frame_bytes, last, output ready);
endinterface

/* rtl/arb_store.sv */
// Sample store: even and odd sample banks, one write and one paired read per cycle.
// Depends on arb_pkg (mem_req_t, BANK_AW).
module arb_store (
	input  logic              clk,
	input  arb_pkg::mem_req_t req,
	output logic [15:0]       rd_lo,
	output logic [15:0]       rd_hi
);

	logic [15:0] lo_mem [2**arb_pkg::BANK_AW];
	logic [15:0] hi_mem [2**arb_pkg::BANK_AW];

	// write into the bank picked by the low sample index bit
	always_ff @(posedge clk) begin
		if (req.we && !req.wbank) begin
			lo_mem[req.waddr] <= req.wdata;
		end
		if (req.we && req.wbank) begin
			hi_mem[req.waddr] <= req.wdata;
		end
	end

	// registered read of both halves of one frame word; data holds while re is low
	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_lo <= lo_mem[req.raddr];
			rd_hi <= hi_mem[req.raddr];
		end
	end

endmodule

/* rtl/audio_ring_buffer_adaptive_frames.sv */
// Channel   | dir | handshake      | payload
// ----------+-----+----------------+----------------------------------------------
// in_items  | in  | valid/ready    | kind, sample, block_len, first/last_of_block
// out_items | out | valid/ready    | status, frame_word, frame_bytes, last
// APB       | in  | psel/penable   | paddr[3:2] register, pwdata, prdata
//
// Samples can be taken every cycle while idle and while the result register is free.
// A frame request of n words first does one store read to prime, then loads one word
// per cycle out of the paired-bank read port while the output does not stall; no new
// item is taken until the last word of the frame has been loaded.
// Reset clears pointers, fill count and start-up state; store contents are not cleared.
// Output stalls hold the word in the result register and pause the store read.
// Depends on arb_pkg, arb_stream_if and arb_store.
module audio_ring_buffer_adaptive_frames (
	input  logic        clk,
	input  logic        arst_n,
	arb_in_if.sink      in_items,
	arb_out_if.source   out_items,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_DATA = 3'b100
	} state_t;

	state_t state_q;

	// configuration
	logic [5:0]  nominal_q;
	logic [12:0] lower_q;
	logic [12:0] upper_q;
	logic [12:0] start_q;

	// buffer state
	logic [arb_pkg::SAMPLE_AW-1:0] wr_idx_q;
	logic [arb_pkg::BANK_AW-1:0]   rd_idx_q;
	logic [arb_pkg::FILL_W-1:0]    fill_q;
	logic                          running_q;
	logic                          dropping_q;
	logic [7:0]                    size_q;
	logic [5:0]                    words_left_q;

	// result register
	logic             out_valid_q;
	arb_pkg::status_t out_status_q;
	logic [31:0]      out_word_q;
	logic [7:0]       out_bytes_q;
	logic             out_last_q;

	logic              out_free;
	logic              in_acc;
	logic              cfg_wr;
	arb_pkg::mem_req_t mem_req;
	logic [15:0]       rd_lo;
	logic [15:0]       rd_hi;

	// write admission
	logic [arb_pkg::FILL_W-1:0] room;
	logic [arb_pkg::FILL_W-1:0] need;
	logic                       drop_cur;
	logic                       can_store;
	logic                       do_store;
	logic                       drop_next;

	// frame sizing
	logic [5:0]                 nom_words;
	logic [7:0]                 nominal;
	logic [7:0]                 grown;
	logic [7:0]                 size;
	logic                       frame_empty;
	logic                       frame_wait;

	// result load
	logic             out_load;
	arb_pkg::status_t load_status;
	logic [31:0]      load_word;
	logic [7:0]       load_bytes;
	logic             load_last;
	logic             last_word;

	assign out_free  = !out_valid_q || out_items.ready;
	assign in_items.ready = (state_q == S_IDLE) && out_free;
	assign in_acc    = in_items.valid && in_items.ready;
	assign last_word = (words_left_q == 6'd1);

	assign out_items.valid       = out_valid_q;
	assign out_items.status      = out_status_q;
	assign out_items.frame_word  = out_word_q;
	assign out_items.frame_bytes = out_bytes_q;
	assign out_items.last        = out_last_q;

	// room check for a write block, judged on its first sample
	always_comb begin
		room      = arb_pkg::FILL_W'(arb_pkg::BUFFER_BYTES) - fill_q;
		need      = arb_pkg::FILL_W'({in_items.block_len, 1'b0});
		drop_cur  = in_items.first_of_block ? (room < need) : dropping_q;
		can_store = fill_q <= arb_pkg::FILL_W'(arb_pkg::BUFFER_BYTES - 2);
		do_store  = !drop_cur && can_store;
		drop_next = drop_cur || !can_store;
	end

	// frame size: saturated nominal, trimmed or grown by one word while running
	always_comb begin
		if (nominal_q < arb_pkg::MIN_FRAME_WORDS) begin
			nom_words = arb_pkg::MIN_FRAME_WORDS;
		end else if (nominal_q > arb_pkg::MAX_FRAME_WORDS) begin
			nom_words = arb_pkg::MAX_FRAME_WORDS;
		end else begin
			nom_words = nominal_q;
		end
		nominal     = {nom_words, 2'b00};
		grown       = nominal + arb_pkg::STEP_BYTES;
		frame_empty = fill_q < arb_pkg::FILL_W'(nominal);
		frame_wait  = !running_q && (fill_q < arb_pkg::FILL_W'(start_q));
		if (running_q && (fill_q < arb_pkg::FILL_W'(lower_q))) begin
			size = nominal - arb_pkg::STEP_BYTES;
		end else if (running_q && (fill_q > arb_pkg::FILL_W'(upper_q))
			&& (fill_q >= arb_pkg::FILL_W'(grown))) begin
			size = grown;
		end else begin
			size = nominal;
		end
	end

	// store access: sample write on accept, paired read to prime or to prefetch
	always_comb begin
		mem_req.we    = in_acc && (in_items.kind == arb_pkg::KIND_WRITE) && do_store;
		mem_req.wbank = wr_idx_q[0];
		mem_req.waddr = wr_idx_q[arb_pkg::SAMPLE_AW-1:1];
		mem_req.wdata = in_items.sample;
		mem_req.re    = (state_q == S_READ)
			|| ((state_q == S_DATA) && out_free && !last_word);
		mem_req.raddr = (state_q == S_READ) ? rd_idx_q : rd_idx_q + 1'b1;
	end

	arb_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rd_lo (rd_lo),
		.rd_hi (rd_hi)
	);

	// what goes into the result register this cycle
	always_comb begin
		out_load    = 1'b0;
		load_status = arb_pkg::ST_OK;
		load_word   = 32'd0;
		load_bytes  = 8'd0;
		load_last   = 1'b1;
		if (in_acc && (in_items.kind == arb_pkg::KIND_WRITE)) begin
			out_load    = in_items.last_of_block;
			load_status = drop_next ? arb_pkg::ST_OVERFLOW : arb_pkg::ST_OK;
		end else if (in_acc) begin
			out_load    = frame_empty || frame_wait;
			load_status = frame_empty ? arb_pkg::ST_EMPTY : arb_pkg::ST_FILLING;
		end else if ((state_q == S_DATA) && out_free) begin
			out_load   = 1'b1;
			load_word  = {rd_hi, rd_lo};
			load_bytes = size_q;
			load_last  = last_word;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= load_status;
			out_word_q   <= load_word;
			out_bytes_q  <= load_bytes;
			out_last_q   <= load_last;
		end
	end

	// configuration decode
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (arb_pkg::reg_idx_t'(paddr[3:2]))
			arb_pkg::REG_NOMINAL: prdata = 32'(nominal_q);
			arb_pkg::REG_LOWER:   prdata = 32'(lower_q);
			arb_pkg::REG_UPPER:   prdata = 32'(upper_q);
			arb_pkg::REG_START:   prdata = 32'(start_q);
			default:              prdata = 32'd0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			nominal_q    <= 6'd48;
			lower_q      <= 13'd1940;
			upper_q      <= 13'd2156;
			start_q      <= 13'd2046;
			wr_idx_q     <= '0;
			rd_idx_q     <= '0;
			fill_q       <= '0;
			running_q    <= 1'b0;
			dropping_q   <= 1'b0;
			size_q       <= '0;
			words_left_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (arb_pkg::reg_idx_t'(paddr[3:2]))
					arb_pkg::REG_NOMINAL: nominal_q <= pwdata[5:0];
					arb_pkg::REG_LOWER:   lower_q   <= pwdata[12:0];
					arb_pkg::REG_UPPER:   upper_q   <= pwdata[12:0];
					arb_pkg::REG_START:   start_q   <= pwdata[12:0];
					default: ;
				endcase
			end

			// result stays valid until taken; a new item loads only when free
			out_valid_q <= out_load || (out_valid_q && !out_items.ready);

			unique case (state_q)
				S_IDLE: begin
					if (in_acc && (in_items.kind == arb_pkg::KIND_WRITE)) begin
						if (do_store) begin
							wr_idx_q <= wr_idx_q + 1'b1;
							fill_q   <= fill_q + arb_pkg::FILL_W'(2);
						end
						dropping_q <= in_items.last_of_block ? 1'b0 : drop_next;
					end else if (in_acc) begin
						if (frame_empty) begin
							running_q <= 1'b0;
						end else if (!frame_wait) begin
							running_q    <= 1'b1;
							size_q       <= size;
							words_left_q <= size[7:2];
							fill_q       <= fill_q - arb_pkg::FILL_W'(size);
							state_q      <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_DATA;
				end
				S_DATA: begin
					if (out_free) begin
						rd_idx_q     <= rd_idx_q + 1'b1;
						words_left_q <= words_left_q - 1'b1;
						if (last_word) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/arb_checker.sv */
// Port-level checks for audio_ring_buffer_adaptive_frames, bound to the top level.
// Depends on arb_pkg for status and kind codes.
module arb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_kind,
	input logic        in_last_of_block,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_status,
	input logic [31:0] out_frame_word,
	input logic [7:0]  out_frame_bytes,
	input logic        out_last
);

	// closing sample of a write block is followed by an OK or overflow status item
	a_block_report: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_kind == arb_pkg::KIND_WRITE) && in_last_of_block
		|=> out_valid && out_last
			&& ((out_status == arb_pkg::ST_OK) || (out_status == arb_pkg::ST_OVERFLOW)))
		else $error("write block end gave no status item");

	// overflow, empty and filling are single items with no frame data
	a_status_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status != arb_pkg::ST_OK)
		|-> out_last && (out_frame_word == 32'd0) && (out_frame_bytes == 8'd0))
		else $error("status item carries frame data");

	// frame words carry a whole-word length within the grown maximum
	a_frame_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_frame_bytes != 8'd0)
		|-> (out_status == arb_pkg::ST_OK) && (out_frame_bytes[1:0] == 2'b00)
			&& (out_frame_bytes >= 8'd4) && (out_frame_bytes <= 8'd196))
		else $error("frame length out of range");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready
		|=> out_valid && $stable(out_status) && $stable(out_frame_word)
			&& $stable(out_frame_bytes) && $stable(out_last))
		else $error("result changed while stalled");

endmodule

bind audio_ring_buffer_adaptive_frames arb_checker u_arb_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_items.valid),
	.in_ready         (in_items.ready),
	.in_kind          (in_items.kind),
	.in_last_of_block (in_items.last_of_block),
	.out_valid        (out_items.valid),
	.out_ready        (out_items.ready),
	.out_status       (out_items.status),
	.out_frame_word   (out_items.frame_word),
	.out_frame_bytes  (out_items.frame_bytes),
	.out_last         (out_items.last)
);
